FILE: rtl/fqd_pkg.sv
`default_nettype none

package fqd_pkg;

  // Queue geometry.
  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Fixed widths of the channel fields.
  localparam int REQ_W   = 3;
  localparam int ITEM_W  = 32;
  localparam int OUT_W   = 32;
  localparam int COUNT_W = 5;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Request codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_DEL    = 3'd2,
    REQ_ITER   = 3'd3,
    REQ_LENGTH = 3'd4
  } req_code_t;

  // Operation broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_ENQ  = 3'd1,
    CELL_DEQ  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_ROT  = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    data_t      key;   // value to append or to look for
    data_t      head;  // value at the head, wrapped to the tail on a rotate
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/fqd_req_if.sv
`default_nettype none

interface fqd_req_if;
  import fqd_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/fqd_rsp_if.sv
`default_nettype none

interface fqd_rsp_if;
  import fqd_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [OUT_W-1:0]   out_value;
  logic [COUNT_W-1:0] count_now;
  logic               last_of_run;

  modport source (output valid, output status, output out_value, output count_now,
                  output last_of_run, input ready);
  modport sink   (input valid, input status, input out_value, input count_now,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/fqd_cell.sv
`default_nettype none

module fqd_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fqd_pkg::cell_ctl_t ctl,
  input  wire logic              left_valid,
  input  wire logic              right_valid,
  input  wire fqd_pkg::data_t    right_value,
  input  wire logic              seen_in,
  output fqd_pkg::data_t         value,
  output logic                   valid,
  output logic                   seen_out
);
  import fqd_pkg::*;

  logic  match;
  logic  shift;
  data_t value_next;
  logic  valid_next;

  // Everything from the first removed entry onward moves one place to the head.
  assign match    = (ctl.mode == CELL_DEL) && valid && (value == ctl.key);
  assign seen_out = seen_in || match;
  assign shift    = ((ctl.mode == CELL_DEL) || (ctl.mode == CELL_DEQ)) && seen_out;

  always_comb begin
    value_next = value;
    valid_next = valid;
    unique case (ctl.mode)
      CELL_ENQ: begin
        if (!valid && left_valid) begin
          value_next = ctl.key;
          valid_next = 1'b1;
        end
      end
      CELL_DEQ, CELL_DEL: begin
        if (shift) begin
          value_next = right_value;
          valid_next = right_valid;
        end
      end
      CELL_ROT: begin
        if (valid) begin
          value_next = right_valid ? right_value : ctl.head;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fifo_queue_with_delete.sv
`default_nettype none

// Bounded queue of nonzero handles with delete by value, built as a row of
// DEPTH cells that keep the entries packed from the head in cell 0. One
// request is taken at a time on req and answered on rsp. Enqueue, dequeue,
// delete and length are done in the cycle of the transfer and their single
// result sits in the output register from the next cycle. Delete compares
// the key in every cell at once and a match flag ripples down the row, so
// the first match from the head and every entry behind it move one cell
// forward. Iterate rotates the row once per result: cell 0 is shown on rsp
// and wrapped to the tail, so after count results the order is as before.
// A single-result request holds req only in the cycle of its transfer, and
// an iterate holds it from its transfer until its last result is loaded,
// one result each time the output is free. The next request is taken
// once the output register is free, so back-to-back single-result
// requests run at one every cycle while the consumer keeps up. An iterate
// of an empty queue gives one result with a zero value. Null enqueue, full,
// empty and missed deletes return status 1 and leave the queue unchanged.
module fifo_queue_with_delete (
  input wire logic clk,
  input wire logic rst,
  fqd_req_if.sink   req,
  fqd_rsp_if.source rsp
);
  import fqd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ITER = 2'b10
  } state_t;

  state_t    state, state_next;
  cnt_t      count, count_next;
  cnt_t      remain, remain_next;
  cell_ctl_t ctl;

  data_t value [DEPTH];
  logic  valid [DEPTH];
  logic  seen  [DEPTH];

  // Output register.
  logic               rsp_valid;
  logic               rsp_status;
  logic [OUT_W-1:0]   rsp_value;
  logic [COUNT_W-1:0] rsp_count;
  logic               rsp_last;

  logic               load_rsp;
  logic               status_next;
  logic [OUT_W-1:0]   out_next;
  logic               last_next;

  logic  take;
  logic  out_free;
  logic  full;
  logic  empty;
  logic  found;
  data_t key;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign take      = req.valid && req.ready;
  assign key       = DATA_W'(req.item_value);
  assign full      = valid[DEPTH-1];
  assign empty     = !valid[0];
  assign found     = seen[DEPTH-1];

  // The row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  left_v;
    logic  right_v;
    data_t right_d;
    logic  seen_i;

    if (i == 0) begin : g_head
      assign left_v = 1'b1;
      assign seen_i = (ctl.mode == CELL_DEQ);
    end else begin : g_body
      assign left_v = valid[i-1];
      assign seen_i = seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = 1'b0;
      assign right_d = '0;
    end else begin : g_inner
      assign right_v = valid[i+1];
      assign right_d = value[i+1];
    end

    fqd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (left_v),
      .right_valid (right_v),
      .right_value (right_d),
      .seen_in     (seen_i),
      .value       (value[i]),
      .valid       (valid[i]),
      .seen_out    (seen[i])
    );
  end

  // Operation sent down the row. Failed requests leave the row alone; a delete
  // without a match moves nothing because no cell sees a match.
  always_comb begin
    ctl.mode = CELL_HOLD;
    ctl.key  = key;
    ctl.head = value[0];
    if (state == ST_ITER) begin
      if (out_free) begin
        ctl.mode = CELL_ROT;
      end
    end else if (take) begin
      unique case (req.req_type)
        REQ_ENQ: if (key != '0 && !full) ctl.mode = CELL_ENQ;
        REQ_DEQ: if (!empty) ctl.mode = CELL_DEQ;
        REQ_DEL: if (key != '0) ctl.mode = CELL_DEL;
        default: ctl.mode = CELL_HOLD;
      endcase
    end
  end

  // Result and count.
  always_comb begin
    state_next  = state;
    count_next  = count;
    remain_next = remain;
    load_rsp    = 1'b0;
    status_next = 1'b0;
    out_next    = '0;
    last_next   = 1'b1;
    unique case (state)
      ST_ITER: begin
        if (out_free) begin
          load_rsp    = 1'b1;
          out_next    = OUT_W'(value[0]);
          last_next   = (remain == cnt_t'(1));
          remain_next = remain - cnt_t'(1);
          if (remain == cnt_t'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        if (take) begin
          load_rsp = 1'b1;
          unique case (req.req_type)
            REQ_ENQ: begin
              if (key == '0 || full) begin
                status_next = 1'b1;
              end else begin
                count_next = count + cnt_t'(1);
              end
            end
            REQ_DEQ: begin
              if (empty) begin
                status_next = 1'b1;
              end else begin
                out_next   = OUT_W'(value[0]);
                count_next = count - cnt_t'(1);
              end
            end
            REQ_DEL: begin
              if (found && key != '0) begin
                count_next = count - cnt_t'(1);
              end else begin
                status_next = 1'b1;
              end
            end
            REQ_ITER: begin
              // A non-empty queue is walked in the following cycles instead.
              if (!empty) begin
                load_rsp    = 1'b0;
                remain_next = count;
                state_next  = ST_ITER;
              end
            end
            REQ_LENGTH: begin
            end
            default: begin
              status_next = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_status <= status_next;
      rsp_value  <= out_next;
      rsp_count  <= COUNT_W'(count_next);
      rsp_last   <= last_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.out_value   = rsp_value;
  assign rsp.count_now   = rsp_count;
  assign rsp.last_of_run = rsp_last;

endmodule

`default_nettype wire

FILE: bench/tb_fifo_queue_with_delete.sv
`timescale 1ns / 1ps

// Directed and random test of the handle queue with delete by value.
//
// Requests go in on the req channel and answers come back on the rsp channel.
// The bench keeps its own copy of the queue contents. Whenever a request is
// transferred, the bench works out the answers that request must produce and
// appends them to a list of answers still due. Every answer transferred on rsp
// is compared, field by field, with the oldest answer on that list.
module tb_fifo_queue_with_delete;
  import fqd_pkg::*;

  // Request codes that the block does not define. They must fail with no
  // change to the queue.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS = 260;
  // Longest stretch the receiver holds ready low on purpose.
  localparam int LONG_HOLD    = 160;
  // The block answers from a register loaded at the transfer, so a short tail
  // is enough to catch a stray extra answer.
  localparam int DRAIN_CYCLES = 20;
  // Cycles with no transfer on either channel before the run is called hung.
  localparam int STALL_LIMIT  = 2000;

  // One answer as it should appear on the rsp channel.
  typedef struct {
    logic               status;
    logic [OUT_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fqd_req_if req_ch ();
  fqd_rsp_if rsp_ch ();

  fifo_queue_with_delete u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Handles held by the block, head first, as the bench believes them to be.
  data_t   held_handles[$];
  // Answers predicted but not yet seen on rsp, oldest first.
  answer_t answers_due[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  // When clear, neither side inserts random idle cycles.
  bit idle_on      = 1'b1;
  // A nonzero value makes the receiver hold ready low for that many cycles
  // after its next transfer.
  int hold_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Every answer reports the number of entries left once the request is done,
  // so each one is queued after the contents have been updated.
  function automatic void add_answer(logic status, data_t value, logic last);
    answer_t a;
    a.status = status;
    a.value  = OUT_W'(value);
    a.count  = COUNT_W'(held_handles.size());
    a.last   = last;
    answers_due.push_back(a);
  endfunction

  // Applies one transferred request to the queue copy and lists its answers.
  function automatic void apply_request(logic [REQ_W-1:0] code, data_t value);
    int hit;
    int i;
    hit = -1;
    case (code)
      REQ_ENQ: begin
        // A null handle is never stored, and a full queue refuses the append.
        if (value == '0 || held_handles.size() >= DEPTH) begin
          add_answer(1'b1, '0, 1'b1);
        end else begin
          held_handles.push_back(value);
          add_answer(1'b0, '0, 1'b1);
        end
      end
      REQ_DEQ: begin
        if (held_handles.size() == 0) begin
          add_answer(1'b1, '0, 1'b1);
        end else begin
          data_t oldest;
          oldest = held_handles.pop_front();
          add_answer(1'b0, oldest, 1'b1);
        end
      end
      REQ_DEL: begin
        // Only the first match from the head goes; the rest keep their order.
        // Null matches nothing since it is never stored.
        if (value != '0) begin
          for (i = 0; i < held_handles.size() && hit < 0; i++) begin
            if (held_handles[i] == value) hit = i;
          end
        end
        if (hit >= 0) begin
          held_handles.delete(hit);
          add_answer(1'b0, '0, 1'b1);
        end else begin
          add_answer(1'b1, '0, 1'b1);
        end
      end
      REQ_ITER: begin
        // An empty queue still gives one answer, a successful zero.
        if (held_handles.size() == 0) begin
          add_answer(1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < held_handles.size(); i++) begin
            add_answer(1'b0, held_handles[i], i == held_handles.size() - 1);
          end
        end
      end
      REQ_LENGTH: begin
        add_answer(1'b0, '0, 1'b1);
      end
      default: begin
        add_answer(1'b1, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge where it is transferred, with
  // valid still high. Whoever calls next either drops valid or offers the
  // next request in that same step, so valid never gets two assignments.
  task automatic send_request(logic [REQ_W-1:0] code, data_t value);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= code;
    req_ch.item_value <= ITEM_W'(value);
    // ready is read right after the edge, so it is the value the block
    // presented at that edge.
    do @(posedge clk); while (!req_ch.ready);
    apply_request(code, value);
  endtask

  // Waits at least one cycle and then until every predicted answer is in.
  task automatic wait_until_answered();
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // About half the handles come from a small pool, so that duplicates are
  // common and a delete has to pick the first of several matches. The rest are
  // nearly all handles across the full width, with now and then a null.
  function automatic data_t pick_handle();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 11) return data_t'($urandom_range(1, 12));
    return data_t'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // The receiver draws a stall before every answer. A long hold requested by
  // a test replaces the draw once and is counted out here.
  initial begin : rsp_receiver
    int stall;
    rsp_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Answers are checked on the falling edge. Nothing changes between that
  // edge and the next rising one, so valid and ready seen here are exactly
  // the transfer that follows, and predictions made at rising edges are
  // always in place before they are needed.
  always @(negedge clk) begin : check_answers
    answer_t due;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected answer: status %0d out_value 0x%08h count_now %0d last %0d",
               rsp_ch.status, rsp_ch.out_value, rsp_ch.count_now, rsp_ch.last_of_run);
        mismatches++;
      end else begin
        due = answers_due.pop_front();
        if (rsp_ch.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.out_value !== due.value) begin
          $error("out_value: expected 0x%08h, got 0x%08h", due.value, rsp_ch.out_value);
          mismatches++;
        end
        if (rsp_ch.count_now !== due.count) begin
          $error("count_now: expected %0d, got %0d", due.count, rsp_ch.count_now);
          mismatches++;
        end
        if (rsp_ch.last_of_run !== due.last) begin
          $error("last_of_run: expected %0d, got %0d", due.last, rsp_ch.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Ends a hung run: a long stretch with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_fifo_queue_with_delete: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every request on an empty queue, the all-zero and all-one handles, a
  // duplicate where delete must take the first copy, missed and null deletes,
  // and each undefined request code.
  task automatic test_directed_cases();
    send_request(REQ_LENGTH, '0);
    send_request(REQ_DEQ, '0);
    send_request(REQ_ITER, '0);
    send_request(REQ_DEL, data_t'(5));
    send_request(REQ_ENQ, '0);
    send_request(REQ_ENQ, '1);
    send_request(REQ_ENQ, data_t'(1));
    send_request(REQ_ENQ, data_t'(32'h8000_0000));
    send_request(REQ_ENQ, data_t'(1));
    send_request(REQ_ITER, '0);
    send_request(REQ_DEL, data_t'(1));
    send_request(REQ_DEL, data_t'(32'h0000_1234));
    send_request(REQ_DEL, '0);
    send_request(REQ_ITER, '0);
    send_request(REQ_DEQ, '0);
    send_request(REQ_UNUSED_LO, data_t'(7));
    send_request(REQ_UNUSED_LO + 3'd1, '1);
    send_request(REQ_UNUSED_HI, '0);
    send_request(REQ_LENGTH, '0);
    send_request(REQ_DEL, data_t'(1));
    send_request(REQ_DEQ, '0);
    send_request(REQ_DEQ, '0);
  endtask

  // The receiver stops for a long stretch while appends keep coming, so the
  // answer register fills and the block has to push back on req. The queue
  // then runs past full, is walked at full depth (the longest answer run),
  // loses its tail and head by value, and is emptied by dequeue.
  task automatic test_fill_under_backpressure();
    int k;
    int left;
    hold_cycles = LONG_HOLD;
    for (k = 0; k < DEPTH + 2; k++) begin
      send_request(REQ_ENQ, data_t'($urandom_range(1, 32'hFFFF_FFFF)));
    end
    send_request(REQ_ITER, '0);
    if (held_handles.size() != 0) send_request(REQ_DEL, held_handles[$]);
    if (held_handles.size() != 0) send_request(REQ_DEL, held_handles[0]);
    left = held_handles.size();
    for (k = 0; k <= left; k++) begin
      send_request(REQ_DEQ, '0);
    end
  endtask

  // The sender goes quiet until every answer is in, then resumes on an idle
  // block.
  task automatic test_pause_until_drained();
    int k;
    for (k = 0; k < 5; k++) begin
      send_request(REQ_ENQ, pick_handle());
    end
    req_ch.valid <= 1'b0;
    wait_until_answered();
    send_request(REQ_LENGTH, '0);
    send_request(REQ_ITER, '0);
  endtask

  // Random traffic. Appends get a larger share while the queue is short;
  // from four handles up the mix stays fixed, with appends ahead of
  // removals. The fill level sweeps the whole range. Most deletes name a
  // handle that is really held. Idling is switched off for some stretches.
  task automatic test_random_traffic(int n);
    int               k;
    int               roll;
    int               fill;
    int               enq_w;
    logic [REQ_W-1:0] code;
    data_t            value;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      fill  = held_handles.size();
      enq_w = (fill < 4) ? 55 : (fill > 13) ? 20 : 38;
      roll  = $urandom_range(0, 99);
      value = pick_handle();
      if (roll < 3) begin
        code  = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        value = data_t'($urandom());
      end else if (roll < 3 + enq_w) begin
        code = REQ_ENQ;
      end else if (roll < 18 + enq_w) begin
        code = REQ_DEQ;
      end else if (roll < 41 + enq_w) begin
        code = REQ_DEL;
        if (fill != 0 && $urandom_range(0, 3) != 0) begin
          value = held_handles[$urandom_range(0, fill - 1)];
        end
      end else if (roll < 47 + enq_w) begin
        code = REQ_ITER;
      end else if (roll < 52 + enq_w) begin
        code = REQ_LENGTH;
      end else begin
        code = REQ_ENQ;
      end
      send_request(code, value);
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LENGTH;
    req_ch.item_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_under_backpressure();
    test_pause_until_drained();
    test_random_traffic(RANDOM_ITEMS);

    // Everything is sent. Wait for the last answers, then a little longer so
    // that a stray extra answer would be caught.
    req_ch.valid <= 1'b0;
    wait_until_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_fifo_queue_with_delete: done, clean");
    end else begin
      $display("tb_fifo_queue_with_delete: done, errors");
    end
    $finish;
  end

endmodule

FILE: fifo_queue_with_delete.f
rtl/fqd_pkg.sv
rtl/fqd_req_if.sv
rtl/fqd_rsp_if.sv
rtl/fqd_cell.sv
rtl/fifo_queue_with_delete.sv
bench/tb_fifo_queue_with_delete.sv
